[hdl/clw_pkg.sv]
// shared types, constants and tables for the 4-bit character lcd writer
`default_nettype none
package clw_pkg;

	typedef enum logic [1:0] {
		CMD_INIT   = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_SETCUR = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		JOB_INIT  = 2'd0,
		JOB_CLEAR = 2'd1,
		JOB_ONE   = 2'd2,
		JOB_TWO   = 2'd3
	} job_kind_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] char_code;
		logic [1:0] row;
		logic [5:0] column;
	} cmd_req_t;

	typedef struct packed {
		logic       strobe_res;
		logic       register_select;
		logic [3:0] nibble;
		logic [5:0] wait_ms;
		logic       last;
	} lcd_item_t;

	typedef struct packed {
		job_kind_t  kind;
		logic       rs0;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} job_t;

	localparam logic [5:0] LINE_LENGTH_RST = 6'd20;
	localparam logic [5:0] WAIT_FULL       = 6'd3;
	localparam logic [5:0] WAIT_CLEAR      = 6'd13;
	localparam logic [5:0] WAIT_POWER_UP   = 6'd50;
	localparam logic [7:0] INSTR_CLEAR     = 8'h01;
	localparam logic [3:0] INIT_LAST_IDX   = 4'd14;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0:    b = 8'h80;
			2'd1:    b = 8'hC0;
			2'd2:    b = 8'h94;
			default: b = 8'hD4;
		endcase
		return b;
	endfunction

	function automatic lcd_item_t init_item(input logic [3:0] idx);
		lcd_item_t it;
		it = '{strobe_res: 1'b1, register_select: 1'b0, nibble: 4'h0,
			wait_ms: 6'd0, last: 1'b0};
		case (idx)
			4'd0: begin
				it.strobe_res = 1'b0;
				it.wait_ms = WAIT_POWER_UP;
			end
			4'd1, 4'd2, 4'd3: begin
				it.nibble = 4'h3;
				it.wait_ms = WAIT_FULL;
			end
			4'd4: begin
				it.nibble = 4'h2;
				it.wait_ms = WAIT_FULL;
			end
			4'd5:  it.nibble = 4'h2;
			4'd6: begin
				it.nibble = 4'h8;
				it.wait_ms = WAIT_FULL;
			end
			4'd7:  it.nibble = 4'h0;
			4'd8: begin
				it.nibble = 4'h1;
				it.wait_ms = WAIT_FULL;
			end
			4'd9:  it.nibble = 4'h1;
			4'd10: begin
				it.nibble = 4'h0;
				it.wait_ms = WAIT_FULL;
			end
			4'd11: it.nibble = 4'h0;
			4'd12: begin
				it.nibble = 4'h6;
				it.wait_ms = WAIT_FULL;
			end
			4'd13: it.nibble = 4'h0;
			4'd14: begin
				it.nibble = 4'hC;
				it.wait_ms = WAIT_FULL;
				it.last = 1'b1;
			end
			default: it.strobe_res = 1'b0;
		endcase
		return it;
	endfunction

endpackage
`default_nettype wire

[hdl/clw_front.sv]
// front end: takes commands, tracks the cursor and forms byte jobs
`default_nettype none
module clw_front import clw_pkg::*; #(
	parameter int unsigned MAX_ROW = 3
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire cmd_req_t   in_req,
	input  wire logic       q_full,
	output logic            push,
	output job_t            push_job
);
	localparam logic [1:0] MaxRow = 2'(MAX_ROW);

	logic [5:0] line_length_q;
	logic [1:0] cursor_row_q;
	logic [5:0] cursor_col_q;
	logic [1:0] row_sat;
	logic [6:0] next_col;
	logic       wrap;
	logic [1:0] wrap_row;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		row_sat  = (in_req.row > MaxRow) ? MaxRow : in_req.row;
		next_col = {1'b0, cursor_col_q} + 7'd1;
		wrap     = next_col >= {1'b0, line_length_q};
		wrap_row = (cursor_row_q >= MaxRow) ? 2'd0 : cursor_row_q + 2'd1;
	end

	always_comb begin
		push_job = '{kind: JOB_ONE, rs0: 1'b0, byte0: 8'h00, byte1: 8'h00};
		case (in_req.command)
			CMD_INIT: push_job.kind = JOB_INIT;
			CMD_CLEAR: begin
				push_job.kind  = JOB_CLEAR;
				push_job.byte0 = INSTR_CLEAR;
				push_job.byte1 = row_base(2'd0);
			end
			CMD_SETCUR: begin
				push_job.byte0 = row_base(row_sat) + {2'b00, in_req.column};
			end
			default: begin
				push_job.kind  = wrap ? JOB_TWO : JOB_ONE;
				push_job.rs0   = 1'b1;
				push_job.byte0 = in_req.char_code;
				push_job.byte1 = row_base(wrap_row);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RST;
			cursor_row_q  <= 2'd0;
			cursor_col_q  <= 6'd0;
		end else begin
			if (cfg_we) begin
				line_length_q <= cfg_wdata;
			end
			if (push) begin
				case (in_req.command)
					CMD_INIT, CMD_CLEAR: begin
						cursor_row_q <= 2'd0;
						cursor_col_q <= 6'd0;
					end
					CMD_SETCUR: begin
						cursor_row_q <= row_sat;
						cursor_col_q <= in_req.column;
					end
					default: begin
						if (wrap) begin
							cursor_row_q <= wrap_row;
							cursor_col_q <= 6'd0;
						end else begin
							cursor_col_q <= next_col[5:0];
						end
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[hdl/clw_queue.sv]
// two-entry job queue between front and back end
`default_nettype none
module clw_queue import clw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);
	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/clw_back.sv]
// back end: expands jobs into nibble bus items, one per cycle unless stalled
`default_nettype none
module clw_back import clw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire job_t head_job,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output lcd_item_t out_item
);
	logic [3:0] idx_q;
	logic       out_valid_q;
	lcd_item_t  out_item_q;
	logic       advance;
	logic [7:0] sel_byte;
	lcd_item_t  item;

	assign advance   = head_valid && (!out_valid_q || out_ready);
	assign pop       = advance && item.last;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		sel_byte = idx_q[1] ? head_job.byte1 : head_job.byte0;
		item.strobe_res      = 1'b1;
		item.register_select = idx_q[1] ? 1'b0 : head_job.rs0;
		item.nibble          = idx_q[0] ? sel_byte[3:0] : sel_byte[7:4];
		if (!idx_q[0]) begin
			item.wait_ms = 6'd0;
		end else if (head_job.kind == JOB_CLEAR && !idx_q[1]) begin
			item.wait_ms = WAIT_CLEAR;
		end else begin
			item.wait_ms = WAIT_FULL;
		end
		case (head_job.kind)
			JOB_INIT: item = init_item(idx_q);
			JOB_ONE:  item.last = idx_q[1:0] == 2'd1;
			default:  item.last = idx_q[1:0] == 2'd3;
		endcase
		if (head_job.kind == JOB_INIT) begin
			item.last = idx_q == INIT_LAST_IDX;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= item.last ? 4'd0 : idx_q + 4'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/char_lcd_4bit_writer.sv]
// top level of the 4-bit character lcd writer
//
//   channel  direction  handshake            payload
//   in       in         in_valid/in_ready    in_req   (cmd_req_t)
//   out      out        out_valid/out_ready  out_item (lcd_item_t)
//   cfg      in         cfg_we               cfg_wdata (line length)
//
// a command is taken and queued as a job (two entries deep)
// the back end sends one bus item per cycle unless stalled: 15 for init,
// 4 for clear, 2 for set cursor, 2 or 4 for a character write
// reset clears cursor, queue and output; line length resets to 20
// a stalled output holds the item and the queue absorbs up to two commands
`default_nettype none
module char_lcd_4bit_writer import clw_pkg::*; #(
	parameter int unsigned ROW_COUNT = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire cmd_req_t   in_req,
	output logic            out_valid,
	input  wire logic       out_ready,
	output lcd_item_t       out_item
);
	localparam int unsigned MaxRow = ROW_COUNT - 1;

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	clw_front #(.MAX_ROW(MaxRow)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	clw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	clw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_job  (head_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && out_item.last)
		else $error("job retired without a last item");
`endif

endmodule
`default_nettype wire
